// ===== sv/bls_pkg.sv =====
// Shared types and constants for the Bresenham line stepper.
package bls_pkg;

  localparam int unsigned CoordBits  = 12;
  localparam int unsigned ErrBits    = CoordBits + 4;
  localparam int unsigned ColorBits  = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    CmdStart   = 1'b0,
    CmdAdvance = 1'b1
  } cmd_e;

  // One classified request, as handed from the front part to the back part.
  typedef struct packed {
    cmd_e                 kind;
    logic [CoordBits-1:0] start_x;
    logic [CoordBits-1:0] start_y;
    logic [CoordBits-1:0] major_end;
    logic [CoordBits-1:0] major_len;
    logic [CoordBits-1:0] minor_len;
    logic                 step_x_neg;
    logic                 step_y_neg;
    logic                 x_major;
    logic [ColorBits-1:0] color;
  } line_req_t;

endpackage

// ===== sv/bresenham_line_stepper.sv =====
// Top level of the all-octant Bresenham line stepper.
//
// Takes one request per clock while the queue has room: a start request (tuser = 0) latches two
// clipped screen endpoints and an RGBA8 colour and emits nothing; an advance
// request (tuser = 1) emits the current pixel of the active line and steps
// it, with tlast on the final pixel (the end point itself is never drawn).
// Advances with no active line, and lines of zero length, emit nothing. A
// start while a line is running drops the old line. The front part works out
// the deltas, major axis and step directions in the accepting cycle; a
// two-entry request queue separates it from the back part, which seeds the
// decision term on a start and on each advance does one add and compare,
// writing the pixel into an output register. Sustained rate is one request
// per clock when the output is not stalled; a request's pixel passes through the
// queue, then the output register, and only output back-pressure slows the
// block down. Equal deltas count as x-major.
module bresenham_line_stepper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] start_x, [23:12] start_y, [35:24] end_x, [47:36] end_y, [79:48] color
  input  logic [79:0] s_axis_tdata,
  // [0] command
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] pixel_x, [23:12] pixel_y, [55:24] pixel_color
  output logic [55:0] m_axis_tdata,
  // last
  output logic        m_axis_tlast
);

  localparam int unsigned CB = bls_pkg::CoordBits;

  bls_pkg::line_req_t        front_req;
  bls_pkg::line_req_t        head_req;
  logic                      queue_full;
  logic                      push;
  logic                      pop;
  logic                      head_valid;
  logic [CB-1:0]             pixel_x;
  logic [CB-1:0]             pixel_y;
  logic [bls_pkg::ColorBits-1:0] pixel_color;

  // Accept whenever the queue has room.
  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  bls_front u_front (
    .cmd_i     (s_axis_tuser[0]),
    .start_x_i (s_axis_tdata[11:0]),
    .start_y_i (s_axis_tdata[23:12]),
    .end_x_i   (s_axis_tdata[35:24]),
    .end_y_i   (s_axis_tdata[47:36]),
    .color_i   (s_axis_tdata[79:48]),
    .req_o     (front_req)
  );

  bls_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_req_i   (front_req),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_req_o   (head_req)
  );

  bls_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_req_i    (head_req),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .last_o        (m_axis_tlast)
  );

  // Pack the pixel fields, lowest field first.
  assign m_axis_tdata = {pixel_color, pixel_y, pixel_x};

endmodule

// ===== sv/bls_front.sv =====
// Front part: decodes a request and classifies the line's slope and directions.
module bls_front (
  input  logic                          cmd_i,
  input  logic [bls_pkg::CoordBits-1:0] start_x_i,
  input  logic [bls_pkg::CoordBits-1:0] start_y_i,
  input  logic [bls_pkg::CoordBits-1:0] end_x_i,
  input  logic [bls_pkg::CoordBits-1:0] end_y_i,
  input  logic [bls_pkg::ColorBits-1:0] color_i,
  output bls_pkg::line_req_t            req_o
);

  logic [bls_pkg::CoordBits:0]   dx;
  logic [bls_pkg::CoordBits:0]   dy;
  logic [bls_pkg::CoordBits:0]   dx_neg;
  logic [bls_pkg::CoordBits:0]   dy_neg;
  logic [bls_pkg::CoordBits-1:0] abs_dx;
  logic [bls_pkg::CoordBits-1:0] abs_dy;
  logic                          x_major;

  assign dx     = {1'b0, end_x_i} - {1'b0, start_x_i};
  assign dy     = {1'b0, end_y_i} - {1'b0, start_y_i};
  assign dx_neg = -dx;
  assign dy_neg = -dy;

  // Magnitudes always fit in the coordinate width.
  assign abs_dx  = dx[bls_pkg::CoordBits] ? dx_neg[bls_pkg::CoordBits-1:0]
                                          : dx[bls_pkg::CoordBits-1:0];
  assign abs_dy  = dy[bls_pkg::CoordBits] ? dy_neg[bls_pkg::CoordBits-1:0]
                                          : dy[bls_pkg::CoordBits-1:0];
  assign x_major = abs_dx >= abs_dy;

  always_comb begin
    req_o.kind       = bls_pkg::cmd_e'(cmd_i);
    req_o.start_x    = start_x_i;
    req_o.start_y    = start_y_i;
    req_o.major_end  = x_major ? end_x_i : end_y_i;
    req_o.major_len  = x_major ? abs_dx : abs_dy;
    req_o.minor_len  = x_major ? abs_dy : abs_dx;
    req_o.step_x_neg = dx[bls_pkg::CoordBits];
    req_o.step_y_neg = dy[bls_pkg::CoordBits];
    req_o.x_major    = x_major;
    req_o.color      = color_i;
  end

endmodule

// ===== sv/bls_queue.sv =====
// Short request queue between the front and back parts.
module bls_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bls_pkg::line_req_t push_req_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               head_valid_o,
  output bls_pkg::line_req_t head_req_o
);

  localparam int unsigned PtrBits = $clog2(bls_pkg::QueueDepth);
  localparam int unsigned CntBits = $clog2(bls_pkg::QueueDepth + 1);

  bls_pkg::line_req_t entry_q [bls_pkg::QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  assign full_o       = count_q == CntBits'(bls_pkg::QueueDepth);
  assign head_valid_o = count_q != '0;
  assign head_req_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(bls_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(bls_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(bls_pkg::QueueDepth))
    else $error("request queue holds more than its depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("request pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("request popped from an empty queue");
`endif

endmodule

// ===== sv/bls_back.sv =====
// Back part: holds the line state, steps it and registers the emitted pixel.
module bls_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  bls_pkg::line_req_t            head_req_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bls_pkg::CoordBits-1:0] pixel_x_o,
  output logic [bls_pkg::CoordBits-1:0] pixel_y_o,
  output logic [bls_pkg::ColorBits-1:0] pixel_color_o,
  output logic                          last_o
);

  localparam int unsigned CB = bls_pkg::CoordBits;
  localparam int unsigned EB = bls_pkg::ErrBits;

  logic                 active_q, active_d;
  logic [CB-1:0]        cur_x_q, cur_x_d;
  logic [CB-1:0]        cur_y_q, cur_y_d;
  logic [CB-1:0]        major_end_q;
  logic signed [EB-1:0] err_q, err_d;
  logic signed [EB-1:0] inc_straight_q;
  logic signed [EB-1:0] inc_diagonal_q;
  logic                 step_x_neg_q;
  logic                 step_y_neg_q;
  logic                 x_major_q;
  logic [bls_pkg::ColorBits-1:0] color_q;

  logic                 out_valid_q, out_valid_d;
  logic [CB-1:0]        pix_x_q;
  logic [CB-1:0]        pix_y_q;
  logic [bls_pkg::ColorBits-1:0] pix_color_q;
  logic                 pix_last_q, pix_last_d;

  logic                 is_start;
  logic                 can_emit;
  logic                 do_start;
  logic                 do_step;
  logic signed [EB-1:0] major_ext;
  logic signed [EB-1:0] minor_ext;
  logic                 diag;
  logic [CB-1:0]        next_x;
  logic [CB-1:0]        next_y;
  logic [CB-1:0]        step_x;
  logic [CB-1:0]        step_y;

  assign is_start  = head_req_i.kind == bls_pkg::CmdStart;
  assign can_emit  = !out_valid_q || out_ready_i;
  // Starts and idle advances never wait on the output side.
  assign pop_o     = head_valid_i && (is_start || !active_q || can_emit);
  assign do_start  = pop_o && is_start;
  assign do_step   = pop_o && !is_start && active_q;

  assign major_ext = EB'(head_req_i.major_len);
  assign minor_ext = EB'(head_req_i.minor_len);

  assign diag      = !err_q[EB-1];
  assign step_x    = step_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
  assign step_y    = step_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
  assign next_x    = (x_major_q || diag) ? step_x : cur_x_q;
  assign next_y    = (!x_major_q || diag) ? step_y : cur_y_q;

  always_comb begin
    active_d    = active_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pix_last_d  = ((x_major_q ? next_x : next_y) == major_end_q);
    if (do_start) begin
      active_d = head_req_i.major_len != '0;
      cur_x_d  = head_req_i.start_x;
      cur_y_d  = head_req_i.start_y;
      err_d    = (minor_ext <<< 1) - major_ext;
    end else if (do_step) begin
      active_d    = !pix_last_d;
      cur_x_d     = next_x;
      cur_y_d     = next_y;
      err_d       = err_q + (diag ? inc_diagonal_q : inc_straight_q);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      cur_x_q        <= '0;
      cur_y_q        <= '0;
      major_end_q    <= '0;
      err_q          <= '0;
      inc_straight_q <= '0;
      inc_diagonal_q <= '0;
      step_x_neg_q   <= 1'b0;
      step_y_neg_q   <= 1'b0;
      x_major_q      <= 1'b0;
      color_q        <= '0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      err_q       <= err_d;
      if (do_start) begin
        major_end_q    <= head_req_i.major_end;
        inc_straight_q <= minor_ext <<< 1;
        inc_diagonal_q <= (minor_ext - major_ext) <<< 1;
        step_x_neg_q   <= head_req_i.step_x_neg;
        step_y_neg_q   <= head_req_i.step_y_neg;
        x_major_q      <= head_req_i.x_major;
        color_q        <= head_req_i.color;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      pix_x_q     <= cur_x_q;
      pix_y_q     <= cur_y_q;
      pix_color_q <= color_q;
      pix_last_q  <= pix_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_color_o = pix_color_q;
  assign last_o        = pix_last_q;

`ifndef ASSERT_OFF
  a_emit_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(do_step))
    else $error("pixel presented without an active advance");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_step && pix_last_d) |=> !active_q)
    else $error("line still active after its final pixel");

  a_step_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_step |-> can_emit)
    else $error("pixel overwrote one not yet taken");
`endif

endmodule

// ===== tb/bresenham_line_stepper_test.sv =====
// Self-checking testbench for the Bresenham line stepper: queued requests, pixel scoreboard.
`timescale 1ns / 1ps

module bresenham_line_stepper_test;

  localparam int unsigned CoordBits     = bls_pkg::CoordBits;
  localparam int unsigned ColorBits     = bls_pkg::ColorBits;
  localparam int unsigned ErrBits       = bls_pkg::ErrBits;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned RandomItems   = 1850;
  localparam int unsigned PhaseLength   = 150;

  typedef enum logic [1:0] {
    PhaseSteady,
    PhaseSenderIdle,
    PhaseReceiverStall,
    PhaseBothIdle
  } idle_phase_e;

  typedef struct {
    bls_pkg::cmd_e        cmd;
    logic [CoordBits-1:0] sx;
    logic [CoordBits-1:0] sy;
    logic [CoordBits-1:0] ex;
    logic [CoordBits-1:0] ey;
    logic [ColorBits-1:0] colour;
    idle_phase_e          phase;
  } line_request_t;

  typedef struct {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [ColorBits-1:0] colour;
    logic                 last;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [11:0] start_x, [23:12] start_y, [35:24] end_x, [47:36] end_y, [79:48] color
  logic [79:0] s_axis_tdata = '0;
  // [0] command
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [11:0] pixel_x, [23:12] pixel_y, [55:24] pixel_color
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  bresenham_line_stepper i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  line_request_t request_backlog[$];
  pixel_t        pixels_due[$];
  int unsigned   planned_items = 0;
  int unsigned   mismatches = 0;
  int unsigned   quiet_cycles = 0;
  logic          timed_out = 1'b0;
  logic          drain_all = 1'b0;
  idle_phase_e   rx_phase = PhaseSteady;

  // Shadow copy of the line state, kept at the block's widths.
  logic                    ln_active = 1'b0;
  logic [CoordBits-1:0]    px = '0;
  logic [CoordBits-1:0]    py = '0;
  logic [CoordBits-1:0]    major_stop = '0;
  logic signed [ErrBits-1:0] decision = '0;
  logic signed [ErrBits-1:0] d_straight = '0;
  logic signed [ErrBits-1:0] d_diag = '0;
  logic                    neg_x = 1'b0;
  logic                    neg_y = 1'b0;
  logic                    along_x = 1'b0;
  logic [ColorBits-1:0]    ln_colour = '0;

  function automatic logic [CoordBits-1:0] nudge(logic [CoordBits-1:0] v, logic neg);
    return neg ? v - 1'b1 : v + 1'b1;
  endfunction

  function automatic int unsigned sender_idle_pct(idle_phase_e ph);
    case (ph)
      PhaseSenderIdle: return 50;
      PhaseBothIdle:   return 14;
      default:         return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct(idle_phase_e ph);
    case (ph)
      PhaseReceiverStall: return 50;
      PhaseBothIdle:      return 14;
      default:            return 0;
    endcase
  endfunction

  // Advance the shadow line by one accepted request; queue the pixel it draws, if any.
  task automatic trace_line(line_request_t r);
    int     w, h, aw, ah, maj, mnr;
    pixel_t p;
    if (r.cmd == bls_pkg::CmdStart) begin
      w = int'(r.ex) - int'(r.sx);
      h = int'(r.ey) - int'(r.sy);
      aw = w < 0 ? -w : w;
      ah = h < 0 ? -h : h;
      // equal deltas fall to the x-major side
      along_x = aw >= ah;
      neg_x = w < 0;
      neg_y = h < 0;
      maj = along_x ? aw : ah;
      mnr = along_x ? ah : aw;
      decision = ErrBits'(2 * mnr - maj);
      d_straight = ErrBits'(2 * mnr);
      d_diag = ErrBits'(2 * (mnr - maj));
      px = r.sx;
      py = r.sy;
      major_stop = along_x ? r.ex : r.ey;
      ln_colour = r.colour;
      ln_active = maj != 0;
    end else if (ln_active) begin
      p.x = px;
      p.y = py;
      p.colour = ln_colour;
      if (decision < 0) begin
        decision = decision + d_straight;
      end else begin
        decision = decision + d_diag;
        if (along_x) py = nudge(py, neg_y);
        else px = nudge(px, neg_x);
      end
      if (along_x) px = nudge(px, neg_x);
      else py = nudge(py, neg_y);
      p.last = (along_x ? px : py) == major_stop;
      if (p.last) ln_active = 1'b0;
      pixels_due.push_back(p);
    end
  endtask

  function automatic idle_phase_e phase_now();
    return idle_phase_e'((planned_items / PhaseLength) % 4);
  endfunction

  task automatic push_start(logic [CoordBits-1:0] sx, logic [CoordBits-1:0] sy,
                            logic [CoordBits-1:0] ex, logic [CoordBits-1:0] ey,
                            logic [ColorBits-1:0] colour);
    line_request_t r;
    r.cmd = bls_pkg::CmdStart;
    r.sx = sx;
    r.sy = sy;
    r.ex = ex;
    r.ey = ey;
    r.colour = colour;
    r.phase = phase_now();
    request_backlog.push_back(r);
    planned_items++;
  endtask

  // Queue n advances with junk in the data fields; count them toward the plan only if asked.
  task automatic push_advances(int n, bit counted);
    line_request_t r;
    repeat (n) begin
      r.cmd = bls_pkg::CmdAdvance;
      r.sx = CoordBits'($urandom);
      r.sy = CoordBits'($urandom);
      r.ex = CoordBits'($urandom);
      r.ey = CoordBits'($urandom);
      r.colour = $urandom;
      r.phase = phase_now();
      request_backlog.push_back(r);
      if (counted) planned_items++;
    end
  endtask

  // Queue one line of given major length whose endpoints stay on screen.
  task automatic push_short_line(int len);
    int       sx, sy, mnr, dmaj, dmin;
    bit       xm;
    sx = $urandom_range(4095);
    sy = $urandom_range(4095);
    mnr = $urandom_range(len);
    xm = 1'($urandom_range(1));
    dmaj = $urandom_range(1) ? len : -len;
    dmin = $urandom_range(1) ? mnr : -mnr;
    // flip the direction of any axis that would leave the screen
    if (xm) begin
      if (sx + dmaj > 4095 || sx + dmaj < 0) dmaj = -dmaj;
      if (sy + dmin > 4095 || sy + dmin < 0) dmin = -dmin;
      push_start(CoordBits'(sx), CoordBits'(sy), CoordBits'(sx + dmaj),
                 CoordBits'(sy + dmin), $urandom);
    end else begin
      if (sy + dmaj > 4095 || sy + dmaj < 0) dmaj = -dmaj;
      if (sx + dmin > 4095 || sx + dmin < 0) dmin = -dmin;
      push_start(CoordBits'(sx), CoordBits'(sy), CoordBits'(sx + dmin),
                 CoordBits'(sy + dmaj), $urandom);
    end
  endtask

  // Driver: present queued requests, idling at random according to their phase.
  line_request_t shown;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) trace_line(shown);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_backlog.size() != 0 &&
            $urandom_range(99) >= sender_idle_pct(request_backlog[0].phase)) begin
          shown = request_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {shown.colour, shown.ey, shown.ex, shown.sy, shown.sx};
          s_axis_tuser <= shown.cmd;
          rx_phase <= shown.phase;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted pixel with the oldest one due, and stall at random.
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixels_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel x=%0d y=%0d colour=%h last=%b", $time,
                   m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tdata[55:24],
                   m_axis_tlast);
        end else begin
          want = pixels_due.pop_front();
          if (m_axis_tdata[11:0] !== want.x) begin
            mismatches++;
            $display("%0t: pixel_x expected %0d got %0d", $time, want.x, m_axis_tdata[11:0]);
          end
          if (m_axis_tdata[23:12] !== want.y) begin
            mismatches++;
            $display("%0t: pixel_y expected %0d got %0d", $time, want.y, m_axis_tdata[23:12]);
          end
          if (m_axis_tdata[55:24] !== want.colour) begin
            mismatches++;
            $display("%0t: pixel_color expected %h got %h", $time, want.colour,
                     m_axis_tdata[55:24]);
          end
          if (m_axis_tlast !== want.last) begin
            mismatches++;
            $display("%0t: last expected %b got %b", $time, want.last, m_axis_tlast);
          end
        end
      end
      m_axis_tready <= drain_all || $urandom_range(99) >= receiver_stall_pct(rx_phase);
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if (rst_ni && !timed_out) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
        timed_out <= 1'b1;
        $display("%0t: watchdog, no handshake for %0d cycles", $time, WatchdogLimit);
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    // Directed part: advance with no line, zero-length line, each octant class,
    // equal deltas, replacement of a running line, screen corners, colour extremes.
    push_advances(1, 1'b1);
    push_start(12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
    push_advances(1, 1'b1);
    push_start(12'd0, 12'd0, 12'd2, 12'd1, 32'h0000_0000);
    push_advances(3, 1'b1);
    push_start(12'd4095, 12'd4095, 12'd4094, 12'd4093, 32'hFFFF_FFFF);
    push_advances(2, 1'b1);
    push_start(12'd0, 12'd4095, 12'd3, 12'd4092, 32'h1234_5678);
    push_advances(2, 1'b1);
    push_start(12'd0, 12'd0, 12'd4095, 12'd4095, 32'hA5A5_5A5A);
    push_advances(1, 1'b1);
    push_start(12'd4095, 12'd0, 12'd0, 12'd1, 32'h8000_0001);
    push_advances(2, 1'b1);
    push_start(12'd100, 12'd100, 12'd100, 12'd103, 32'h7FFF_FFFE);
    push_advances(3, 1'b1);
    push_start(12'd5, 12'd5, 12'd4, 12'd5, 32'hDEAD_BEEF);
    push_advances(1, 1'b1);

    // Random part: mostly complete short lines, some long, cut short or overrun,
    // plus zero-length starts and wild endpoints.
    while (planned_items < RandomItems + 25) begin
      r = $urandom_range(99);
      if (r < 8) begin
        push_start(CoordBits'($urandom), CoordBits'($urandom), CoordBits'($urandom),
                   CoordBits'($urandom), $urandom);
        push_advances($urandom_range(3), 1'b1);
      end else if (r < 12) begin
        r = $urandom_range(4095);
        push_start(CoordBits'(r), CoordBits'(r) ^ 12'hFFF, CoordBits'(r),
                   CoordBits'(r) ^ 12'hFFF, $urandom);
        push_advances($urandom_range(1), 1'b0);
      end else begin
        r = (r < 15) ? $urandom_range(400, 1) : $urandom_range(12, 1);
        push_short_line(r);
        if ($urandom_range(9) == 0) begin
          push_advances($urandom_range(r, 1), 1'b1);
        end else begin
          push_advances(r, 1'b1);
          push_advances($urandom_range(1), 1'b0);
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!timed_out && (request_backlog.size() != 0 || s_axis_tvalid)) @(posedge clk_i);
    drain_all <= 1'b1;
    while (!timed_out && pixels_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (!timed_out && mismatches == 0 && pixels_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
